### sv/mfhd_pkg.sv
// Shared types and constants for the MQTT fixed header decoder.
package mfhd_pkg;

  typedef enum logic [1:0] {
    ST_AGAIN = 2'd0,
    ST_DONE  = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  localparam logic [3:0] TYPE_LOW         = 4'd1;
  localparam logic [3:0] TYPE_HIGH        = 4'd14;
  localparam logic [3:0] TYPE_PUBLISH     = 4'd3;
  localparam logic [3:0] TYPE_PUBREL      = 4'd6;
  localparam logic [3:0] TYPE_SUBSCRIBE   = 4'd8;
  localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'd10;

  localparam logic [3:0] FLAGS_RESERVED = 4'd2;
  localparam logic [3:0] FLAGS_QOS_MASK = 4'd6;

  localparam int unsigned LEN_W        = 28;
  localparam logic [2:0]  LAST_GROUP   = 3'd3;
  localparam logic [2:0]  BYTES_SAT    = 3'd7;

endpackage

### sv/mfhd_if.sv
// Handshake channels for header bytes in and decode results out.
interface mfhd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_packet;

  modport source (output valid, output data_byte, output new_packet, input ready);
  modport sink   (input valid, input data_byte, input new_packet, output ready);
endinterface

interface mfhd_result_if;
  logic                     valid;
  logic                     ready;
  mfhd_pkg::status_t        status;
  logic [3:0]               packet_type;
  logic                     dup_flag;
  logic [1:0]               qos_level;
  logic                     retain_flag;
  logic [mfhd_pkg::LEN_W-1:0] body_length;

  modport source (output valid, output status, output packet_type, output dup_flag,
                  output qos_level, output retain_flag, output body_length,
                  input ready);
  modport sink   (input valid, input status, input packet_type, input dup_flag,
                  input qos_level, input retain_flag, input body_length,
                  output ready);
endinterface

### sv/mqtt_fixed_header_decoder_top.sv
// MQTT fixed header decoder: input register, decode and length accumulate, result register.
// Flow: a byte accepted into the input register moves on to the result register, where
// its result beat is held until it is taken.
// Throughput: one byte per cycle while the result channel is not stalled; the parser state
// is updated as a byte moves from the input register to the result register, so the next byte sees it at once.
// Reset (rst, synchronous): both registers empty, parser state cleared to zero.
module mqtt_fixed_header_decoder_top (
  input  logic                 clk,
  input  logic                 rst,
  mfhd_byte_if.sink            bytes,
  mfhd_result_if.source        result
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_new_packet;
  logic       s1_advance;

  // Parser state
  logic                       failed_flag;
  logic [2:0]                 bytes_seen;
  logic [3:0]                 type_reg;
  logic                       dup_reg;
  logic [1:0]                 qos_reg;
  logic                       retain_reg;
  logic [2:0]                 group_shift;
  logic [mfhd_pkg::LEN_W-1:0] length_accum;
  logic                       length_done;
  logic [mfhd_pkg::LEN_W-1:0] length_final;

  // State as seen by this byte, after an optional new packet clear
  logic                       cur_failed;
  logic [2:0]                 cur_bytes_seen;
  logic [3:0]                 cur_type;
  logic                       cur_dup;
  logic [1:0]                 cur_qos;
  logic                       cur_retain;
  logic [2:0]                 cur_group_shift;
  logic [mfhd_pkg::LEN_W-1:0] cur_length_accum;
  logic                       cur_length_done;
  logic [mfhd_pkg::LEN_W-1:0] cur_length_final;

  logic                       failed_flag_next;
  logic [2:0]                 bytes_seen_next;
  logic [3:0]                 type_reg_next;
  logic                       dup_reg_next;
  logic [1:0]                 qos_reg_next;
  logic                       retain_reg_next;
  logic [2:0]                 group_shift_next;
  logic [mfhd_pkg::LEN_W-1:0] length_accum_next;
  logic                       length_done_next;
  logic [mfhd_pkg::LEN_W-1:0] length_final_next;

  mfhd_pkg::status_t          status_next;
  logic [3:0]                 first_type;
  logic [3:0]                 first_flags;
  logic                       flags_bad;
  logic                       type_bad;
  logic                       len_bad;
  logic [mfhd_pkg::LEN_W-1:0] group_value;
  logic [mfhd_pkg::LEN_W-1:0] length_sum;

  assign s1_advance  = s1_valid && (!result.valid || result.ready);
  assign bytes.ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (bytes.ready) begin
      s1_valid <= bytes.valid;
    end
    if (bytes.ready && bytes.valid) begin
      s1_byte       <= bytes.data_byte;
      s1_new_packet <= bytes.new_packet;
    end
  end

  always_comb begin
    cur_failed       = s1_new_packet ? 1'b0 : failed_flag;
    cur_bytes_seen   = s1_new_packet ? 3'd0 : bytes_seen;
    cur_type         = s1_new_packet ? 4'd0 : type_reg;
    cur_dup          = s1_new_packet ? 1'b0 : dup_reg;
    cur_qos          = s1_new_packet ? 2'd0 : qos_reg;
    cur_retain       = s1_new_packet ? 1'b0 : retain_reg;
    cur_group_shift  = s1_new_packet ? 3'd0 : group_shift;
    cur_length_accum = s1_new_packet ? '0 : length_accum;
    cur_length_done  = s1_new_packet ? 1'b0 : length_done;
    cur_length_final = s1_new_packet ? '0 : length_final;

    first_type  = s1_byte[7:4];
    first_flags = s1_byte[3:0];
    type_bad    = (first_type < mfhd_pkg::TYPE_LOW) || (first_type > mfhd_pkg::TYPE_HIGH);
    case (first_type)
      mfhd_pkg::TYPE_PUBREL, mfhd_pkg::TYPE_SUBSCRIBE, mfhd_pkg::TYPE_UNSUBSCRIBE:
        flags_bad = first_flags != mfhd_pkg::FLAGS_RESERVED;
      mfhd_pkg::TYPE_PUBLISH:
        flags_bad = (first_flags & mfhd_pkg::FLAGS_QOS_MASK) == mfhd_pkg::FLAGS_QOS_MASK;
      default:
        flags_bad = first_flags != 4'd0;
    endcase

    // A zero byte is only a legal length encoding as the first length byte.
    len_bad = ((cur_group_shift >= mfhd_pkg::LAST_GROUP) && s1_byte[7]) ||
              ((cur_group_shift != 3'd0) && (s1_byte == 8'd0)) ||
              cur_length_done || (cur_group_shift > mfhd_pkg::LAST_GROUP);

    case (cur_group_shift[1:0])
      2'd0:    group_value = {21'd0, s1_byte[6:0]};
      2'd1:    group_value = {14'd0, s1_byte[6:0], 7'd0};
      2'd2:    group_value = {7'd0, s1_byte[6:0], 14'd0};
      default: group_value = {s1_byte[6:0], 21'd0};
    endcase
    length_sum = cur_length_accum + group_value;

    failed_flag_next  = cur_failed;
    bytes_seen_next   = cur_bytes_seen;
    type_reg_next     = cur_type;
    dup_reg_next      = cur_dup;
    qos_reg_next      = cur_qos;
    retain_reg_next   = cur_retain;
    group_shift_next  = cur_group_shift;
    length_accum_next = cur_length_accum;
    length_done_next  = cur_length_done;
    length_final_next = cur_length_final;
    status_next       = mfhd_pkg::ST_AGAIN;

    if (cur_failed) begin
      status_next = mfhd_pkg::ST_ERROR;
    end else if (cur_bytes_seen == 3'd0) begin
      if (type_bad || flags_bad) begin
        status_next = mfhd_pkg::ST_ERROR;
      end else begin
        type_reg_next     = first_type;
        group_shift_next  = 3'd0;
        length_accum_next = '0;
        length_done_next  = 1'b0;
        if (first_type == mfhd_pkg::TYPE_PUBLISH) begin
          dup_reg_next    = first_flags[3];
          qos_reg_next    = first_flags[2:1];
          retain_reg_next = first_flags[0];
        end else begin
          dup_reg_next    = 1'b0;
          qos_reg_next    = 2'd0;
          retain_reg_next = 1'b0;
        end
      end
    end else if (len_bad) begin
      status_next = mfhd_pkg::ST_ERROR;
    end else begin
      length_accum_next = length_sum;
      group_shift_next  = cur_group_shift + 3'd1;
      if (!s1_byte[7]) begin
        status_next       = mfhd_pkg::ST_DONE;
        length_final_next = length_sum;
        length_done_next  = 1'b1;
      end
    end

    if (status_next == mfhd_pkg::ST_ERROR) begin
      failed_flag_next = 1'b1;
    end else if (cur_bytes_seen != mfhd_pkg::BYTES_SAT) begin
      bytes_seen_next = cur_bytes_seen + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failed_flag  <= 1'b0;
      bytes_seen   <= 3'd0;
      type_reg     <= 4'd0;
      dup_reg      <= 1'b0;
      qos_reg      <= 2'd0;
      retain_reg   <= 1'b0;
      group_shift  <= 3'd0;
      length_accum <= '0;
      length_done  <= 1'b0;
      length_final <= '0;
    end else if (s1_advance) begin
      failed_flag  <= failed_flag_next;
      bytes_seen   <= bytes_seen_next;
      type_reg     <= type_reg_next;
      dup_reg      <= dup_reg_next;
      qos_reg      <= qos_reg_next;
      retain_reg   <= retain_reg_next;
      group_shift  <= group_shift_next;
      length_accum <= length_accum_next;
      length_done  <= length_done_next;
      length_final <= length_final_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (!result.valid || result.ready) begin
      result.valid <= s1_valid;
    end
    if (s1_advance) begin
      result.status      <= status_next;
      result.packet_type <= type_reg_next;
      result.dup_flag    <= dup_reg_next;
      result.qos_level   <= qos_reg_next;
      result.retain_flag <= retain_reg_next;
      result.body_length <= (status_next == mfhd_pkg::ST_DONE) ? length_final_next : '0;
    end
  end

  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && failed_flag && !s1_new_packet) |=> (result.status == mfhd_pkg::ST_ERROR))
    else $error("sticky error did not answer error");

  a_qos_legal: assert property (@(posedge clk) disable iff (rst)
    qos_reg != 2'd3)
    else $error("QoS 3 was stored");

  a_flags_publish_only: assert property (@(posedge clk) disable iff (rst)
    (type_reg != mfhd_pkg::TYPE_PUBLISH) |-> (!dup_reg && qos_reg == 2'd0 && !retain_reg))
    else $error("flags held for a type other than PUBLISH");

  a_done_has_group: assert property (@(posedge clk) disable iff (rst)
    length_done |-> (group_shift != 3'd0 && group_shift <= 3'd4))
    else $error("length complete without a length group");

  a_length_only_when_done: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != mfhd_pkg::ST_DONE) |-> (result.body_length == '0))
    else $error("remaining length shown on an unfinished beat");

endmodule
